// File: src/iva_pkg.sv
// ----------------------------------------------------------------------------
// iva_pkg
// shared types, constants and the gate descriptor builder for the interrupt
// vector allocator
// ----------------------------------------------------------------------------
package iva_pkg;

   localparam int TABLE_ENTRIES_DEFAULT = 256;
   localparam int FIRST_DYNAMIC_DEFAULT = 32;

   // used marks are searched in groups of this many bits
   localparam int GROUP_BITS = 16;
   localparam int LOW_W      = $clog2(GROUP_BITS);

   localparam logic [15:0] CODE_SEL_RESET = 16'h0008;

   localparam logic [3:0] GATE_TYPE_INT = 4'hE;
   localparam logic [2:0] GATE_IST      = 3'd0;
   localparam logic [1:0] GATE_DPL      = 2'd0;
   localparam logic       GATE_PRESENT  = 1'b1;

   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 136;

   typedef enum logic [1:0] {
      KIND_ALLOC = 2'd0,
      KIND_FREE  = 2'd1,
      KIND_READ  = 2'd2
   } kind_type;

   typedef enum logic {
      ST_IDLE   = 1'b0,
      ST_COMMIT = 1'b1
   } state_type;

   typedef struct packed {
      logic capture;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

   // low word of a 64-bit interrupt gate
   function automatic logic [63:0] build_gate_low(input logic [63:0] addr,
                                                  input logic [15:0] sel);
      build_gate_low = {addr[31:16], GATE_PRESENT, GATE_DPL, 1'b0, GATE_TYPE_INT,
                        5'd0, GATE_IST, sel, addr[15:0]};
   endfunction

endpackage

// File: src/iva_ctrl.sv
// ----------------------------------------------------------------------------
// iva_ctrl
// sequencer: takes a request beat, then commits it once the output
// register is free
// ----------------------------------------------------------------------------
module iva_ctrl
   import iva_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready  = 1'b0;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         ST_COMMIT: begin
            cmd.commit = status.out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: src/iva_datapath.sv
// ----------------------------------------------------------------------------
// iva_datapath
// used marks with grouped free search, gate table memory with valid bits,
// selector register and output register
// ----------------------------------------------------------------------------
module iva_datapath
   import iva_pkg::*;
#(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT,
   parameter int FIRST_DYNAMIC = FIRST_DYNAMIC_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [15:0]           csr_write_data,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [1:0]            req_tuser,
   input  logic                  rsp_tready,
   output logic                  rsp_tvalid,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [0:0]            rsp_tuser,
   input  cmd_type               cmd,
   output status_type            status
);

   localparam int IDX_W     = $clog2(TABLE_ENTRIES);
   localparam int DYN_COUNT = TABLE_ENTRIES - FIRST_DYNAMIC;
   localparam int GROUPS    = (DYN_COUNT + GROUP_BITS - 1) / GROUP_BITS;
   localparam int GRP_W     = (GROUPS > 1) ? $clog2(GROUPS) : 1;
   localparam int SLOT_W    = GRP_W + LOW_W;
   localparam int PAD_BITS  = GROUPS * GROUP_BITS;

   logic [15:0]              code_sel_ff, code_sel_in;
   logic [1:0]               kind_ff;
   logic [63:0]              addr_ff;
   logic [7:0]               vec_ff;
   logic [DYN_COUNT-1:0]     marks_ff, marks_in;
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic [95:0]              gate_mem_ff [TABLE_ENTRIES];
   logic [95:0]              rd_data_ff;
   logic                     rd_valid_ff;
   logic [IDX_W-1:0]         rd_addr;

   logic [PAD_BITS-1:0]      marks_pad;
   logic [GROUPS-1:0]        grp_free_ff, grp_free_in;
   logic [LOW_W-1:0]         grp_low_ff [GROUPS];
   logic [LOW_W-1:0]         grp_low_in [GROUPS];

   logic                     found;
   logic [SLOT_W-1:0]        slot;
   logic [IDX_W-1:0]         alloc_vec;
   logic [63:0]              alloc_low;
   logic                     free_ok, read_ok;
   logic                     do_alloc, do_free;

   logic                     res_ok;
   logic [7:0]               res_vec;
   logic [63:0]              res_lo;
   logic [31:0]              res_hi;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_ok_ff;
   logic [7:0]               rsp_vec_ff;
   logic [63:0]              rsp_lo_ff;
   logic [31:0]              rsp_hi_ff;

   // selector register
   always_comb begin
      code_sel_in = csr_write_enable ? csr_write_data : code_sel_ff;
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= req_tuser;
         addr_ff <= req_tdata[63:0];
         vec_ff  <= req_tdata[71:64];
      end
   end

   // first level of the free search: lowest clear mark in each group
   always_comb begin
      marks_pad                 = '1;
      marks_pad[DYN_COUNT-1:0]  = marks_ff;
      for (int g = 0; g < GROUPS; g++) begin
         grp_free_in[g] = ~&marks_pad[g*GROUP_BITS +: GROUP_BITS];
         grp_low_in[g]  = '0;
         for (int b = GROUP_BITS - 1; b >= 0; b--) begin
            if (!marks_pad[g*GROUP_BITS + b]) begin
               grp_low_in[g] = LOW_W'(b);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         grp_free_ff <= grp_free_in;
         for (int g = 0; g < GROUPS; g++) begin
            grp_low_ff[g] <= grp_low_in[g];
         end
      end
   end

   // second level: lowest group with a free mark
   always_comb begin
      found = |grp_free_ff;
      slot  = '0;
      for (int g = GROUPS - 1; g >= 0; g--) begin
         if (grp_free_ff[g]) begin
            slot = {GRP_W'(g), grp_low_ff[g]};
         end
      end
      alloc_vec = IDX_W'(FIRST_DYNAMIC) + IDX_W'(slot);
      alloc_low = build_gate_low(addr_ff, code_sel_ff);
   end

   always_comb begin
      free_ok  = (vec_ff >= 8'(FIRST_DYNAMIC)) && ({1'b0, vec_ff} < 9'(TABLE_ENTRIES));
      read_ok  = {1'b0, vec_ff} < 9'(TABLE_ENTRIES);
      do_alloc = cmd.commit && (kind_ff == KIND_ALLOC) && found;
      do_free  = cmd.commit && (kind_ff == KIND_FREE) && free_ok;
   end

   // mark and valid updates; a cleared valid bit reads back as an all-zero gate
   always_comb begin
      for (int i = 0; i < DYN_COUNT; i++) begin
         marks_in[i] = marks_ff[i];
         if (do_alloc && (slot == SLOT_W'(i))) begin
            marks_in[i] = 1'b1;
         end
         if (do_free && (vec_ff == 8'(i + FIRST_DYNAMIC))) begin
            marks_in[i] = 1'b0;
         end
      end
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         valid_in[i] = valid_ff[i];
         if (do_alloc && (alloc_vec == IDX_W'(i))) begin
            valid_in[i] = 1'b1;
         end
         if (do_free && (vec_ff == 8'(i))) begin
            valid_in[i] = 1'b0;
         end
      end
   end

   // gate table, read at capture and written at commit
   assign rd_addr = req_tdata[64 +: IDX_W];

   always_ff @(posedge clock) begin
      if (do_alloc) begin
         gate_mem_ff[alloc_vec] <= {addr_ff[63:32], alloc_low};
      end
      if (cmd.capture) begin
         rd_data_ff  <= gate_mem_ff[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   // result of the committed request
   always_comb begin
      res_ok  = 1'b0;
      res_vec = '0;
      res_lo  = '0;
      res_hi  = '0;
      unique case (kind_ff)
         KIND_ALLOC: begin
            if (found) begin
               res_ok  = 1'b1;
               res_vec = 8'(alloc_vec);
               res_lo  = alloc_low;
               res_hi  = addr_ff[63:32];
            end
         end
         KIND_FREE: begin
            res_ok = free_ok;
         end
         KIND_READ: begin
            res_ok = read_ok;
            if (read_ok && rd_valid_ff) begin
               res_lo = rd_data_ff[63:0];
               res_hi = rd_data_ff[95:64];
            end
         end
         default: begin
            res_ok = 1'b0;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ok_ff  <= res_ok;
         rsp_vec_ff <= res_vec;
         rsp_lo_ff  <= res_lo;
         rsp_hi_ff  <= res_hi;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_sel_ff  <= CODE_SEL_RESET;
         marks_ff     <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         code_sel_ff  <= code_sel_in;
         marks_ff     <= marks_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tuser       = rsp_ok_ff;
   assign rsp_tdata       = {32'd0, rsp_hi_ff, rsp_lo_ff, rsp_vec_ff};

`ifndef SYNTH
   a_commit_fills: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("commit did not load the output register");

   a_commit_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || rsp_tready))
      else $error("commit overwrote a beat not yet taken");

   a_alloc_marks_one: assert property (@(posedge clock) disable iff (reset)
      do_alloc |=> ($countones(marks_ff) == $past($countones(marks_ff)) + 1))
      else $error("allocate did not set exactly one used mark");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ok_ff) |->
         (rsp_vec_ff == 8'd0) && (rsp_lo_ff == 64'd0) && (rsp_hi_ff == 32'd0))
      else $error("failed beat carries non-zero payload");
`endif

endmodule

// File: src/interrupt_vector_allocator.sv
// ----------------------------------------------------------------------------
// interrupt_vector_allocator
// dynamic interrupt vector allocator with a 64-bit interrupt gate table
// ----------------------------------------------------------------------------
// request beats arrive on req_*: tuser carries the kind (allocate, free,
// read), tdata the handler address and the vector. each request gives one
// response beat on rsp_*: tuser carries ok, tdata the granted vector and the
// two gate words.
// allocate takes the lowest free dynamic vector and writes a present ring-0
// interrupt gate built from the handler address and the code selector held
// in the csr register; free clears an entry and its used mark; read returns
// an entry.
// a request is taken only while the sequencer is idle; the response beat is
// presented once the request has been captured and then committed, and a
// new request is taken only after the previous one has committed: the capture
// cycle registers the table read and the grouped free search, the commit
// cycle finishes the search and writes the table.
// a stalled response waits in the output register while the next request is
// taken; that request commits only once the waiting beat has gone.
// reset clears the used marks and the per-entry valid bits at once (no
// clearing pass), so every entry reads as zero; the selector resets to 8.
// ----------------------------------------------------------------------------
module interrupt_vector_allocator
   import iva_pkg::*;
#(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT,
   parameter int FIRST_DYNAMIC = FIRST_DYNAMIC_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,

   // selector register
   input  logic                  csr_write_enable,
   input  logic [15:0]           csr_write_data,

   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // handler_address [63:0], vector [71:64]
   input  logic [1:0]            req_tuser,   // kind [1:0]

   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // granted_vector [7:0], gate_low [71:8],
                                              // gate_high [135:72]
   output logic [0:0]            rsp_tuser    // ok [0]
);

   cmd_type    cmd;
   status_type status;

   // sequencer
   iva_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // marks, table and output register
   iva_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .FIRST_DYNAMIC (FIRST_DYNAMIC)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_tdata        (req_tdata),
      .req_tuser        (req_tuser),
      .rsp_tready       (rsp_tready),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tdata        (rsp_tdata),
      .rsp_tuser        (rsp_tuser),
      .cmd              (cmd),
      .status           (status)
   );

endmodule
